>>> hdl/uer_pkg.sv
package uer_pkg;

    localparam int TIMESTAMP_BITS_DEF = 32;
    localparam int TS_PORT_W          = 32;
    localparam int TEMP_W             = 8;
    localparam int DIST_W             = 16;

    localparam int SPEED_W            = 19;
    localparam int SPEED_SUM_W        = SPEED_W + 1;
    localparam int SPEED_BASE         = 331300;
    localparam int SPEED_SLOPE        = 606;

    localparam longint SPEED_DIVISOR  = 20000000;

    localparam int MUL_W              = 32;
    localparam int PROD_W             = 2 * MUL_W;

    // 20000000 = 2^8 * 78125; the reciprocal of 78125 is exact for any 32-bit dividend
    localparam int DIV_PRE_SHIFT      = 8;
    localparam int RECIP_SHIFT        = 48;
    localparam logic [MUL_W-1:0]  RECIP_MULT  = 32'd3602879702;
    localparam logic [PROD_W-1:0] SAT_PRODUCT = PROD_W'(SPEED_DIVISOR) << (DIST_W - 1);

    localparam logic [DIST_W-1:0] DIST_MAX = 16'h7FFF;
    localparam logic [DIST_W-1:0] NO_ECHO  = 16'hFFFF;

    typedef logic        [TS_PORT_W-1:0] ts_t;
    typedef logic signed [TEMP_W-1:0]    temp_t;
    typedef logic signed [DIST_W-1:0]    dist_t;

endpackage

>>> hdl/ultrasonic_echo_ranging_top.sv
// Echo edge transactions are taken while the sequencer is idle; edges may then arrive every cycle.
// A request without a fresh echo goes straight to ST_FIN, which loads the no-echo code and raises out_valid.
// A request with a fresh echo goes through ST_MUL and ST_REC before ST_FIN:
// one shared multiplier forms width times speed, then scales it by a reciprocal of the divisor.
// The input is not ready from a request until its result is loaded, which waits on out_ready.
// rst_n clears the sequencer, the output valid, the stored start time, width and fresh flag.
module ultrasonic_echo_ranging_top #(
    parameter int TIMESTAMP_BITS = uer_pkg::TIMESTAMP_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           mode,
    input  logic           echo_level,
    input  uer_pkg::ts_t   timestamp_us,
    input  uer_pkg::temp_t temperature_c,
    output logic           out_valid,
    input  logic           out_ready,
    output uer_pkg::dist_t distance_cm
);

    import uer_pkg::*;

    localparam int TS_W    = (TIMESTAMP_BITS < TS_PORT_W) ? TIMESTAMP_BITS : TS_PORT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_REC  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]         state_reg,  state_next;
    logic [TS_W-1:0]    start_reg,  start_next;
    logic [TS_W-1:0]    dur_reg,    dur_next;
    logic               fresh_reg,  fresh_next;
    logic [SPEED_W-1:0] speed_reg,  speed_next;
    logic [PROD_W-1:0]  prod_reg,   prod_next;
    logic               use_result_reg, use_result_next;
    logic [DIST_W-1:0]  result_reg, result_next;
    logic               out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]  dist_reg,   dist_next;

    logic                          in_fire;
    logic [TS_W-1:0]               ts;
    logic signed [SPEED_SUM_W-1:0] temp_ext;
    logic signed [SPEED_SUM_W-1:0] speed_sum;
    logic [MUL_W-1:0]              mul_a;
    logic [MUL_W-1:0]              mul_b;
    logic [PROD_W-1:0]             mul_p;
    logic                          out_free;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign distance_cm = dist_t'(dist_reg);
    assign out_free    = !out_valid_reg || out_ready;

    assign ts        = timestamp_us[TS_W-1:0];
    assign temp_ext  = SPEED_SUM_W'(temperature_c);
    assign speed_sum = temp_ext * SPEED_SUM_W'(SPEED_SLOPE) + SPEED_SUM_W'(SPEED_BASE);

    assign mul_a = (state_reg == ST_MUL) ? MUL_W'(dur_reg) : prod_reg[DIV_PRE_SHIFT +: MUL_W];
    assign mul_b = (state_reg == ST_MUL) ? MUL_W'(speed_reg) : RECIP_MULT;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        dur_next        = dur_reg;
        fresh_next      = fresh_reg;
        speed_next      = speed_reg;
        prod_next       = prod_reg;
        use_result_next = use_result_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg;
        dist_next       = dist_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!mode)
                    begin
                        if (echo_level)
                        begin
                            start_next = ts;
                        end
                        else if (ts > start_reg)
                        begin
                            dur_next   = ts - start_reg;
                            fresh_next = 1'b1;
                        end
                    end
                    else
                    begin
                        fresh_next = 1'b0;
                        if (fresh_reg)
                        begin
                            speed_next = speed_sum[SPEED_W-1:0];
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            result_next     = NO_ECHO;
                            use_result_next = 1'b1;
                            state_next      = ST_FIN;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_REC;
            end
            ST_REC:
            begin
                // saturate when the quotient reaches 2^15, else take the reciprocal product
                use_result_next = (prod_reg >= SAT_PRODUCT);
                result_next     = DIST_MAX;
                prod_next       = mul_p;
                state_next      = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register frees
                if (out_free)
                begin
                    dist_next      = use_result_reg ? result_reg
                                                    : prod_reg[RECIP_SHIFT +: DIST_W];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= '0;
            dur_reg       <= '0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            dur_reg       <= dur_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg      <= speed_next;
        prod_reg       <= prod_next;
        use_result_reg <= use_result_next;
        result_reg     <= result_next;
        dist_reg       <= dist_next;
    end

`ifndef NO_ASSERTIONS
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("output raised without a finished request");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!dist_reg[DIST_W-1] || dist_reg == NO_ECHO))
        else $error("distance negative but not the no-echo code");

    a_request_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode) |=> !fresh_reg)
        else $error("fresh flag survived a request");

    a_mul_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> ($past(state_reg) == ST_IDLE && $past(fresh_reg)))
        else $error("multiply entered without a fresh echo");

    a_rec_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REC) |=> state_reg == ST_FIN)
        else $error("scaling step did not finish");
`endif

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 450;

    typedef struct {
        logic  mode;
        logic  level;
        ts_t   ts;
        temp_t temp;
    } echo_txn_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    logic  mode = 1'b0;
    logic  echo_level = 1'b0;
    ts_t   timestamp_us = '0;
    temp_t temperature_c = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    dist_t distance_cm;

    echo_txn_t pending_items[$];
    dist_t     expected_distance[$];

    ts_t  echo_start = '0;
    ts_t  pulse_width = '0;
    logic width_fresh = 1'b0;

    int sender_idle_pct = 8;
    int receiver_idle_pct = 69;
    int n_fail = 0;
    int cycle_count = 0;

    ultrasonic_echo_ranging_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .echo_level    (echo_level),
        .timestamp_us  (timestamp_us),
        .temperature_c (temperature_c),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .distance_cm   (distance_cm)
    );

    always #5 clk = ~clk;

    function automatic dist_t range_from_width(ts_t width, temp_t temp);
        longint speed;
        longint unsigned product;
        longint unsigned quotient;
        speed = SPEED_BASE + SPEED_SLOPE * longint'(temp);
        product = longint'({32'd0, width}) * speed;
        quotient = product / SPEED_DIVISOR;
        if (quotient > DIST_MAX)
            quotient = DIST_MAX;
        return quotient[DIST_W-1:0];
    endfunction

    function automatic void track_echo(echo_txn_t t);
        if (!t.mode)
        begin
            if (t.level)
                echo_start = t.ts;
            else if (t.ts > echo_start)
            begin
                pulse_width = t.ts - echo_start;
                width_fresh = 1'b1;
            end
        end
        else
        begin
            expected_distance.push_back(width_fresh ? range_from_width(pulse_width, t.temp)
                                                    : NO_ECHO);
            width_fresh = 1'b0;
        end
    endfunction

    task automatic add_item(logic m, logic l, ts_t ts, temp_t tp);
        echo_txn_t t;
        t.mode = m;
        t.level = l;
        t.ts = ts;
        t.temp = tp;
        pending_items.push_back(t);
    endtask

    task automatic add_edge(logic l, ts_t ts);
        add_item(1'b0, l, ts, temp_t'($urandom));
    endtask

    task automatic add_request(temp_t tp);
        add_item(1'b1, 1'($urandom), ts_t'($urandom), tp);
    endtask

    function automatic temp_t random_temperature();
        if ($urandom_range(99) < 85)
            return temp_t'(int'($urandom_range(125)) - 40);
        return temp_t'($urandom);
    endfunction

    function automatic ts_t random_width();
        case ($urandom_range(9))
            6, 7: return ts_t'($urandom_range(1 << 20, 1));
            8: return ts_t'($urandom);
            9: return ts_t'($urandom_range(3));
            default: return ts_t'($urandom_range(40000, 1));
        endcase
    endfunction

    task automatic add_random_items(int n_items);
        int target;
        ts_t t0;
        ts_t w;
        target = pending_items.size() + n_items;
        while (pending_items.size() < target)
        begin
            if ($urandom_range(99) < 75)
            begin
                t0 = ts_t'($urandom);
                w = random_width();
                add_edge(1'b1, t0);
                add_edge(1'b0, t0 + w);
                if ($urandom_range(99) < 15)
                    add_edge(1'b0, t0 + w + ts_t'($urandom_range(5000)));
                add_request(random_temperature());
                if ($urandom_range(99) < 20)
                    add_request(random_temperature());
            end
            else
                add_item(1'($urandom), 1'($urandom), ts_t'($urandom), temp_t'($urandom));
        end
    endtask

    task automatic add_directed_items();
        add_request(temp_t'(0));
        add_edge(1'b0, ts_t'(1000));
        add_request(temp_t'(-128));
        add_request(temp_t'(20));
        add_edge(1'b1, ts_t'(5000));
        add_edge(1'b0, ts_t'(5000));
        add_edge(1'b0, ts_t'(4000));
        add_request(temp_t'(20));
        add_edge(1'b0, ts_t'(6000));
        add_edge(1'b0, ts_t'(9000));
        add_request(temp_t'(127));
        add_edge(1'b1, ts_t'(0));
        add_edge(1'b0, ts_t'('1));
        add_request(temp_t'(85));
        add_edge(1'b1, ts_t'(32'hFFFF_0000));
        add_edge(1'b0, ts_t'('1));
        add_request(temp_t'(-40));
        add_edge(1'b1, ts_t'(100));
        add_edge(1'b0, ts_t'(1266));
        add_item(1'b1, 1'b1, ts_t'('1), temp_t'(20));
        add_item(1'b1, 1'b0, ts_t'(0), temp_t'(-1));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                track_echo('{mode, echo_level, timestamp_us, temperature_c});
            if (in_valid && !in_ready)
            begin
                // hold the transaction until it is taken
            end
            else if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                mode <= pending_items[0].mode;
                echo_level <= pending_items[0].level;
                timestamp_us <= pending_items[0].ts;
                temperature_c <= pending_items[0].temp;
                void'(pending_items.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_distance.size() == 0)
            begin
                $error("distance_cm: no result expected, got %0d", distance_cm);
                n_fail++;
            end
            else
            begin
                if (distance_cm !== expected_distance[0])
                begin
                    $error("distance_cm: expected %0d, got %0d",
                           expected_distance[0], distance_cm);
                    n_fail++;
                end
                void'(expected_distance.pop_front());
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        add_directed_items();
        add_random_items(PHASE_ITEMS - pending_items.size());
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);

        sender_idle_pct = 69;
        receiver_idle_pct = 8;
        add_random_items(PHASE_ITEMS);
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        add_random_items(PHASE_ITEMS);
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);

        while (expected_distance.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> ultrasonic_echo_ranging_top.f
hdl/uer_pkg.sv
hdl/ultrasonic_echo_ranging_top.sv
verif/tb.sv
